// ===== hdl/mefp_pkg.sv =====
// shared types and constants for the midi event frame packer
package mefp_pkg;

  // result kinds
  localparam logic [1:0] KindByte   = 2'd0;
  localparam logic [1:0] KindLength = 2'd1;
  localparam logic [1:0] KindOffset = 2'd2;

  // frame closing byte and poly pressure remap
  localparam logic [7:0]  FrameEnd      = 8'hFD;
  localparam logic [3:0]  NibPolyPress  = 4'hA;
  localparam logic [3:0]  NibControl    = 4'hB;

  // reset values of the packer state
  localparam logic [16:0] FillReset     = 17'd8;
  localparam logic [15:0] HeaderReset   = 16'd4;

  // largest number of results caused by one input transaction
  localparam int unsigned MaxResults = 6;

  typedef struct packed {
    logic        cmd;
    logic [15:0] sample_offset;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] position;
    logic [15:0] value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] previous_offset;
    logic [16:0] fill_level;
    logic [15:0] header_length_pos;
  } state_t;

  typedef struct packed {
    state_t                      next;
    logic [2:0]                  count;
    out_t [MaxResults-1:0]       ent;
  } plan_t;

endpackage

// ===== hdl/mefp_planner.sv =====
// combinational planner: buffer writes and next state for one transaction
module mefp_planner #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned FULL_LIMIT   = 65500
) (
  input  mefp_pkg::in_t    item_i,
  input  mefp_pkg::state_t state_i,
  input  logic             poly_to_control_i,
  output mefp_pkg::plan_t  plan_o
);

  logic        room;
  logic        newer;
  logic        frame_change;
  logic [16:0] fill_p1;
  logic [16:0] fill_p9;
  logic [16:0] msg_base;
  logic [15:0] len_word;
  logic [7:0]  status;
  logic [3:0]  hi;
  logic        msg_two;
  logic        msg_three;
  logic [2:0]  base;

  // admission checks and frame close arithmetic
  assign room = (state_i.fill_level < 17'(FULL_LIMIT)) &&
                (({1'b0, state_i.fill_level} + 18'd13) <= 18'(BUFFER_BYTES));
  assign newer   = item_i.sample_offset >= state_i.previous_offset;
  assign fill_p1 = state_i.fill_level + 17'd1;
  assign fill_p9 = state_i.fill_level + 17'd9;
  assign len_word = fill_p1[15:0] - state_i.header_length_pos - 16'd4;
  assign frame_change = item_i.sample_offset != state_i.previous_offset;
  assign msg_base = frame_change ? fill_p9 : state_i.fill_level;
  assign base     = frame_change ? 3'd3 : 3'd0;

  // status remap and message length
  always_comb begin
    status = item_i.status_byte;
    if (status[7:4] == mefp_pkg::NibPolyPress && poly_to_control_i) begin
      status = {mefp_pkg::NibControl, item_i.status_byte[3:0]};
    end
    hi = status[7:4];
    msg_two   = 1'b0;
    msg_three = 1'b0;
    case (hi) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: msg_three = 1'b1;
      4'hC, 4'hD:                   msg_two   = 1'b1;
      default: ;
    endcase
  end

  // result list and next state
  always_comb begin
    plan_o.next  = state_i;
    plan_o.count = 3'd0;
    for (int i = 0; i < mefp_pkg::MaxResults; i++) begin
      plan_o.ent[i] = '0;
    end
    // frame close entries are shared by flush and offset change
    plan_o.ent[0].kind     = mefp_pkg::KindByte;
    plan_o.ent[0].position = state_i.fill_level[15:0];
    plan_o.ent[0].value    = {8'd0, mefp_pkg::FrameEnd};
    plan_o.ent[1].kind     = mefp_pkg::KindLength;
    plan_o.ent[1].position = state_i.header_length_pos;
    plan_o.ent[1].value    = len_word;
    plan_o.ent[2].kind     = mefp_pkg::KindOffset;
    if (item_i.cmd) begin
      // flush: offset word zero at the buffer start, rewind
      plan_o.ent[2].position = 16'd0;
      plan_o.ent[2].value    = 16'd0;
      plan_o.count                  = 3'd3;
      plan_o.next.previous_offset   = 16'd0;
      plan_o.next.fill_level        = mefp_pkg::FillReset;
      plan_o.next.header_length_pos = mefp_pkg::HeaderReset;
    end else if (room && newer) begin
      plan_o.ent[2].position = fill_p1[15:0];
      plan_o.ent[2].value    = item_i.sample_offset;
      plan_o.next.fill_level = msg_base;
      if (frame_change) begin
        plan_o.next.previous_offset   = item_i.sample_offset;
        plan_o.next.header_length_pos = state_i.fill_level[15:0] + 16'd5;
      end
      if (msg_two || msg_three) begin
        plan_o.ent[base].kind           = mefp_pkg::KindByte;
        plan_o.ent[base].position       = msg_base[15:0];
        plan_o.ent[base].value          = {8'd0, status};
        plan_o.ent[base + 3'd1].kind     = mefp_pkg::KindByte;
        plan_o.ent[base + 3'd1].position = msg_base[15:0] + 16'd1;
        plan_o.ent[base + 3'd1].value    = {8'd0, item_i.data_one};
        plan_o.next.fill_level          = msg_base + 17'd2;
      end
      if (msg_three) begin
        plan_o.ent[base + 3'd2].kind     = mefp_pkg::KindByte;
        plan_o.ent[base + 3'd2].position = msg_base[15:0] + 16'd2;
        plan_o.ent[base + 3'd2].value    = {8'd0, item_i.data_two};
        plan_o.next.fill_level          = msg_base + 17'd3;
      end
      plan_o.count = base + (msg_three ? 3'd3 : (msg_two ? 3'd2 : 3'd0));
    end
  end

endmodule

// ===== hdl/midi_event_frame_packer_unit.sv =====
// top level of the midi event frame packer: handshakes, state and result sequencer
//
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one MIDI event or a
// flush command per transaction. Output channel (out_valid_o, out_stall_i,
// out_data_o) delivers buffer writes: kind, position, value and a last flag on
// the final write caused by a transaction. A dropped event gives no write.
// The cfg channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// poly_to_control bit; it is always ready. The user must write it only while idle;
// the block itself does not enforce it. An accepted transaction is planned in
// the cycle it is taken and its writes are registered into a six-entry result
// list; the first write shows in the next cycle, then one write per cycle while
// out_stall_i is low. A transaction gives up to six writes, possibly none, all
// through the single output port; the next transaction is taken in the cycle
// the last write of the previous one leaves. While the receiver stalls, the
// current write holds and in_stall_o stays high once a list is pending.
// Reset (rst_ni low) empties the list, sets fill to 8, the header length
// position to 4, the previous offset to 0 and poly_to_control to 1.
module midi_event_frame_packer_unit #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned FULL_LIMIT   = 65500
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mefp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mefp_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i
);

  mefp_pkg::state_t state_q;
  logic             poly_q;
  mefp_pkg::plan_t  plan;
  mefp_pkg::out_t   res_q [mefp_pkg::MaxResults];
  logic [2:0]       cnt_q;
  logic [2:0]       idx_q;
  logic             pend_q;
  logic             out_fire;
  logic             last_fire;
  logic             in_fire;
  logic             is_last;

  mefp_planner #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .FULL_LIMIT  (FULL_LIMIT)
  ) u_planner (
    .item_i           (in_data_i),
    .state_i          (state_q),
    .poly_to_control_i(poly_q),
    .plan_o           (plan)
  );

  // handshake control
  assign is_last     = idx_q == (cnt_q - 3'd1);
  assign out_fire    = pend_q && !out_stall_i;
  assign last_fire   = out_fire && is_last;
  assign in_stall_o  = pend_q && !last_fire;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // output view of the current list entry
  always_comb begin
    out_data_o      = res_q[idx_q];
    out_data_o.last = is_last;
  end
  assign out_valid_o = pend_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_q <= cfg_data_i;
    end
  end

  // packer state and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.previous_offset   <= 16'd0;
      state_q.fill_level        <= mefp_pkg::FillReset;
      state_q.header_length_pos <= mefp_pkg::HeaderReset;
      cnt_q  <= 3'd0;
      idx_q  <= 3'd0;
      pend_q <= 1'b0;
    end else if (in_fire) begin
      state_q <= plan.next;
      cnt_q   <= plan.count;
      idx_q   <= 3'd0;
      pend_q  <= plan.count != 3'd0;
    end else if (last_fire) begin
      pend_q <= 1'b0;
    end else if (out_fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  // result list payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < mefp_pkg::MaxResults; i++) begin
        res_q[i] <= plan.ent[i];
      end
    end
  end

endmodule
